FILE: hdl/ssp_pkg.sv
package ssp_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_HEADER   = 3'd2,
        ST_WRONG_ID = 3'd3,
        ST_CHECKSUM = 3'd4
    } status_t;

    // configuration register indexes
    localparam logic CFG_EXPECTED_ID    = 1'b0;
    localparam logic CFG_WRAP_THRESHOLD = 1'b1;

    localparam logic [7:0]  HEADER_BYTE     = 8'hFF;
    localparam logic [7:0]  SIGN_BIT        = 8'h80;
    localparam logic [7:0]  MAG_MASK        = 8'h7F;
    localparam logic [7:0]  MIN_PACKET_IDX  = 8'd5;   // count of 6 bytes
    localparam logic [7:0]  TELEM_LAST_IDX  = 8'd12;  // count of 13 bytes
    localparam logic [7:0]  MIN_TELEM_LEN   = 8'd9;
    localparam logic [7:0]  PAYLOAD_IDX     = 8'd5;
    localparam logic [7:0]  IDX_MAX         = 8'd255;
    localparam int          PAYLOAD_DEPTH   = 8;

    // packet summary handed from the byte collector to the telemetry stage
    typedef struct packed {
        logic                  done;
        status_t               status;
        logic [7:0]            error;
        logic                  telem;
        logic [7:0][7:0]       payload;
    } pkt_info_t;

    typedef struct packed {
        logic [2:0]            parse_status;
        logic [7:0]            servo_error;
        logic signed [15:0]    single_turn_pos;
        logic signed [15:0]    multi_turn_pos;
        logic signed [15:0]    turns;
        logic signed [15:0]    speed_value;
        logic signed [15:0]    load_value;
        logic [8:0]            supply_voltage;
        logic [7:0]            temperature;
        logic                  data_updated;
    } result_t;

    function automatic logic [15:0] sign_mag(input logic [7:0] lo, input logic [7:0] hi);
        logic [15:0] mag;
        mag = {hi & MAG_MASK, lo};
        return ((hi & SIGN_BIT) != 8'd0) ? 16'(16'd0 - mag) : mag;
    endfunction

endpackage

FILE: hdl/ssp_if.sv
interface ssp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_packet;

    modport source (output valid, output rx_byte, output end_of_packet, input ready);
    modport sink   (input valid, input rx_byte, input end_of_packet, output ready);
endinterface

interface ssp_report_if;
    logic               valid;
    logic               ready;
    logic [2:0]         parse_status;
    logic [7:0]         servo_error;
    logic signed [15:0] single_turn_pos;
    logic signed [15:0] multi_turn_pos;
    logic signed [15:0] turns;
    logic signed [15:0] speed_value;
    logic signed [15:0] load_value;
    logic [8:0]         supply_voltage;
    logic [7:0]         temperature;
    logic               data_updated;

    modport source (
        output valid, output parse_status, output servo_error, output single_turn_pos,
        output multi_turn_pos, output turns, output speed_value, output load_value,
        output supply_voltage, output temperature, output data_updated, input ready
    );
    modport sink (
        input valid, input parse_status, input servo_error, input single_turn_pos,
        input multi_turn_pos, input turns, input speed_value, input load_value,
        input supply_voltage, input temperature, input data_updated, output ready
    );
endinterface

FILE: hdl/ssp_collect.sv
module ssp_collect
    import ssp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    ssp_byte_if.sink          bytes,
    input  logic              take,
    input  logic [7:0]        expected_id,
    output pkt_info_t         pkt
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eop_reg;

    logic [7:0] byte_index_reg, byte_index_next;
    logic       header_ok_reg,  header_ok_next;
    logic [7:0] id_seen_reg,    id_seen_next;
    logic [7:0] length_reg,     length_next;
    logic [7:0] error_reg,      error_next;
    logic [7:0] sum_reg,        sum_next;
    logic [7:0] payload_reg [PAYLOAD_DEPTH];

    logic       fire;
    logic [7:0] b;
    logic [7:0] idx;

    assign b    = s1_byte_reg;
    assign idx  = byte_index_reg;
    assign fire = s1_valid_reg && (!s1_eop_reg || take);
    assign bytes.ready = !s1_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            s1_valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            s1_byte_reg <= bytes.rx_byte;
            s1_eop_reg  <= bytes.end_of_packet;
        end
    end

    // current byte folded into the packet state
    always_comb
    begin
        header_ok_next = header_ok_reg;
        if ((idx == 8'd0 || idx == 8'd1) && b != HEADER_BYTE)
        begin
            header_ok_next = 1'b0;
        end
        id_seen_next = (idx == 8'd2) ? b : id_seen_reg;
        length_next  = (idx == 8'd3) ? b : length_reg;
        error_next   = (idx == 8'd4) ? b : error_reg;
        sum_next        = (idx >= 8'd2) ? 8'(sum_reg + b) : sum_reg;
        byte_index_next = (idx != IDX_MAX) ? 8'(idx + 8'd1) : idx;
    end

    always_comb
    begin
        pkt.done  = s1_valid_reg && s1_eop_reg && take;
        pkt.error = error_next;
        pkt.telem = (length_next >= MIN_TELEM_LEN) && (idx >= TELEM_LAST_IDX);
        for (int k = 0; k < PAYLOAD_DEPTH; k++)
        begin
            pkt.payload[k] = (idx == 8'(PAYLOAD_IDX + 8'(k))) ? b : payload_reg[k];
        end
        if (idx < MIN_PACKET_IDX)
        begin
            pkt.status = ST_SHORT;
        end
        else if (!header_ok_next)
        begin
            pkt.status = ST_HEADER;
        end
        else if (id_seen_next != expected_id)
        begin
            pkt.status = ST_WRONG_ID;
        end
        else if (~sum_reg != b)
        begin
            pkt.status = ST_CHECKSUM;
        end
        else
        begin
            pkt.status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= 8'd0;
            header_ok_reg  <= 1'b1;
            sum_reg        <= 8'd0;
            id_seen_reg    <= 8'd0;
            length_reg     <= 8'd0;
            error_reg      <= 8'd0;
        end
        else if (fire)
        begin
            id_seen_reg <= id_seen_next;
            length_reg  <= length_next;
            error_reg   <= error_next;
            if (s1_eop_reg)
            begin
                byte_index_reg <= 8'd0;
                header_ok_reg  <= 1'b1;
                sum_reg        <= 8'd0;
            end
            else
            begin
                byte_index_reg <= byte_index_next;
                header_ok_reg  <= header_ok_next;
                sum_reg        <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int k = 0; k < PAYLOAD_DEPTH; k++)
            begin
                if (idx == 8'(PAYLOAD_IDX + 8'(k)))
                begin
                    payload_reg[k] <= b;
                end
            end
        end
    end

endmodule

FILE: hdl/ssp_telemetry.sv
module ssp_telemetry
    import ssp_pkg::*;
#(
    parameter int STEPS_PER_TURN = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  pkt_info_t   pkt,
    input  logic [11:0] wrap_threshold,
    output result_t     res
);

    localparam logic [15:0] STEP_INC = 16'(STEPS_PER_TURN);

    logic [15:0] last_pos_reg;
    logic [15:0] turn_reg,       turn_next;
    logic [15:0] turn_steps_reg, turn_steps_next;  // turn_reg * STEPS_PER_TURN, wrapped
    logic        first_reg;

    logic        update;
    logic [15:0] pos;
    logic [15:0] diff;
    logic [16:0] mag;
    logic        ok;

    assign ok     = (pkt.status == ST_OK);
    assign update = pkt.done && ok && pkt.telem;
    assign pos    = {pkt.payload[1], pkt.payload[0]};
    assign diff   = 16'(pos - last_pos_reg);
    assign mag    = diff[15] ? 17'(17'd0 - {1'b1, diff}) : {1'b0, diff};

    always_comb
    begin
        turn_next       = turn_reg;
        turn_steps_next = turn_steps_reg;
        if (!first_reg && mag > {5'd0, wrap_threshold})
        begin
            if (diff[15])
            begin
                turn_next       = 16'(turn_reg + 16'd1);
                turn_steps_next = 16'(turn_steps_reg + STEP_INC);
            end
            else
            begin
                turn_next       = 16'(turn_reg - 16'd1);
                turn_steps_next = 16'(turn_steps_reg - STEP_INC);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pos_reg   <= 16'd0;
            turn_reg       <= 16'd0;
            turn_steps_reg <= 16'd0;
            first_reg      <= 1'b1;
        end
        else if (update)
        begin
            last_pos_reg   <= pos;
            turn_reg       <= turn_next;
            turn_steps_reg <= turn_steps_next;
            first_reg      <= 1'b0;
        end
    end

    always_comb
    begin
        res = '0;
        res.parse_status = pkt.status;
        if (ok)
        begin
            res.servo_error = pkt.error;
        end
        if (update)
        begin
            res.single_turn_pos = pos;
            res.multi_turn_pos  = 16'(turn_steps_next + pos);
            res.turns           = turn_next;
            res.speed_value     = sign_mag(pkt.payload[2], pkt.payload[3]);
            res.load_value      = sign_mag(pkt.payload[4], pkt.payload[5]);
            res.supply_voltage  = 9'({1'b0, pkt.payload[6]} + 9'd1);
            res.temperature     = pkt.payload[7];
            res.data_updated    = 1'b1;
        end
    end

endmodule

FILE: hdl/servo_status_packet_parser.sv
// channel   dir   payload                                    request moves
// bytes     in    rx_byte, end_of_packet                     valid & ready
// report    out   parse_status .. data_updated (10 fields)   valid & ready
// cfg       in    cfg_wen, cfg_idx, cfg_data                 cfg_wen
//
// One byte per cycle sustained while no end byte waits. Each byte is registered in the input
// register first; an end byte's report is then registered in the output register.
// Only end bytes wait on a full output register; other bytes flow through.
// Reset: expected_id 1, wrap_threshold 2048, no packet in progress, no turns.
module servo_status_packet_parser
    import ssp_pkg::*;
#(
    parameter int STEPS_PER_TURN = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    ssp_byte_if.sink     bytes,
    ssp_report_if.source report,
    input  logic         cfg_wen,
    input  logic         cfg_idx,
    input  logic [11:0]  cfg_data
);

    logic [7:0]  expected_id_reg;
    logic [11:0] wrap_threshold_reg;
    logic        out_valid_reg;
    result_t     res_reg;
    result_t     res;
    pkt_info_t   pkt;
    logic        take;

    assign take = !out_valid_reg || report.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg    <= 8'd1;
            wrap_threshold_reg <= 12'd2048;
        end
        else if (cfg_wen)
        begin
            case (cfg_idx)
                CFG_EXPECTED_ID:    expected_id_reg    <= cfg_data[7:0];
                CFG_WRAP_THRESHOLD: wrap_threshold_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    ssp_collect u_collect (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes       (bytes),
        .take        (take),
        .expected_id (expected_id_reg),
        .pkt         (pkt)
    );

    ssp_telemetry #(
        .STEPS_PER_TURN (STEPS_PER_TURN)
    ) u_telemetry (
        .clk            (clk),
        .rst_n          (rst_n),
        .pkt            (pkt),
        .wrap_threshold (wrap_threshold_reg),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pkt.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt.done)
        begin
            res_reg <= res;
        end
    end

    assign report.valid           = out_valid_reg;
    assign report.parse_status    = res_reg.parse_status;
    assign report.servo_error     = res_reg.servo_error;
    assign report.single_turn_pos = res_reg.single_turn_pos;
    assign report.multi_turn_pos  = res_reg.multi_turn_pos;
    assign report.turns           = res_reg.turns;
    assign report.speed_value     = res_reg.speed_value;
    assign report.load_value      = res_reg.load_value;
    assign report.supply_voltage  = res_reg.supply_voltage;
    assign report.temperature     = res_reg.temperature;
    assign report.data_updated    = res_reg.data_updated;

endmodule

FILE: verif/servo_status_packet_parser_checker.sv
`timescale 1ns / 100ps

module servo_status_packet_parser_checker
    import ssp_pkg::*;
#(
    parameter int STEPS_PER_TURN = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    ssp_byte_if         byte_mon,
    ssp_report_if       report_mon,
    input  logic        cfg_wen,
    input  logic        cfg_idx,
    input  logic [11:0] cfg_data,
    output int          mismatches,
    output int          pending,
    output int          reports_checked,
    output int          telemetry_reports
);

    // register copies
    logic [7:0]  want_id;
    logic [11:0] wrap_lim;

    // per-packet collector state
    logic [7:0]  idx_r;
    logic        hdr_r;
    logic [7:0]  id_r;
    logic [7:0]  len_r;
    logic [7:0]  err_r;
    logic [7:0]  sum_r;
    logic [7:0]  pay_r [8];

    // multi-turn tracking across packets
    logic [15:0] pos_now;
    logic [15:0] pos_prev;
    logic [15:0] turns_r;
    logic        fresh_r;

    result_t     pending_reports [$];

    function automatic logic [15:0] magnitude_to_twos(input logic [7:0] lo, input logic [7:0] hi);
        logic [15:0] m;
        m = {1'b0, hi[6:0], lo};
        return hi[7] ? -m : m;
    endfunction

    function automatic string show(input result_t r);
        return {$sformatf("st=%0d err=%02h pos=%0d glob=%0d turns=%0d ",
                    r.parse_status, r.servo_error, $signed(r.single_turn_pos),
                    $signed(r.multi_turn_pos), $signed(r.turns)),
                $sformatf("spd=%0d load=%0d volt=%0d temp=%0d upd=%0b",
                    $signed(r.speed_value), $signed(r.load_value), r.supply_voltage,
                    r.temperature, r.data_updated)};
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic eop);
        result_t            r;
        logic [8:0]         count;
        logic signed [15:0] delta;
        int                 dmag;
        logic [31:0]        glob;

        if (idx_r <= 8'd1 && b != HEADER_BYTE)
            hdr_r = 1'b0;
        if (idx_r == 8'd2)
            id_r = b;
        if (idx_r == 8'd3)
            len_r = b;
        if (idx_r == 8'd4)
            err_r = b;
        if (idx_r >= 8'd5 && idx_r <= 8'd12)
            pay_r[3'(idx_r - 8'd5)] = b;

        if (!eop)
        begin
            if (idx_r >= 8'd2)
                sum_r = sum_r + b;
            if (idx_r != 8'hFF)
                idx_r = idx_r + 8'd1;
            return;
        end

        count = {1'b0, idx_r} + 9'd1;
        r = '0;
        if (count < 9'd6)
            r.parse_status = ST_SHORT;
        else if (!hdr_r)
            r.parse_status = ST_HEADER;
        else if (id_r != want_id)
            r.parse_status = ST_WRONG_ID;
        else if (~sum_r != b)
            r.parse_status = ST_CHECKSUM;
        else
            r.parse_status = ST_OK;

        if (r.parse_status == ST_OK)
        begin
            r.servo_error = err_r;
            if (len_r >= 8'd9 && count >= 9'd13)
            begin
                pos_prev = pos_now;
                pos_now  = {pay_r[1], pay_r[0]};
                if (fresh_r)
                begin
                    pos_prev = pos_now;
                    fresh_r  = 1'b0;
                end
                else
                begin
                    // wrapped difference taken as signed
                    delta = pos_now - pos_prev;
                    dmag  = (delta < 0) ? -int'(delta) : int'(delta);
                    if (dmag > int'(wrap_lim))
                        turns_r = (delta < 0) ? turns_r + 16'd1 : turns_r - 16'd1;
                end
                glob = 32'(turns_r) * 32'(STEPS_PER_TURN) + 32'(pos_now);
                r.single_turn_pos = pos_now;
                r.multi_turn_pos  = glob[15:0];
                r.turns           = turns_r;
                r.speed_value     = magnitude_to_twos(pay_r[2], pay_r[3]);
                r.load_value      = magnitude_to_twos(pay_r[4], pay_r[5]);
                r.supply_voltage  = {1'b0, pay_r[6]} + 9'd1;
                r.temperature     = pay_r[7];
                r.data_updated    = 1'b1;
            end
        end

        pending_reports.push_back(r);
        idx_r = 8'd0;
        hdr_r = 1'b1;
        sum_r = 8'd0;
    endtask

    task automatic check_report();
        result_t got;
        result_t want;

        got.parse_status    = report_mon.parse_status;
        got.servo_error     = report_mon.servo_error;
        got.single_turn_pos = report_mon.single_turn_pos;
        got.multi_turn_pos  = report_mon.multi_turn_pos;
        got.turns           = report_mon.turns;
        got.speed_value     = report_mon.speed_value;
        got.load_value      = report_mon.load_value;
        got.supply_voltage  = report_mon.supply_voltage;
        got.temperature     = report_mon.temperature;
        got.data_updated    = report_mon.data_updated;

        if (pending_reports.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: report with none expected: %s", $time, show(got));
            return;
        end

        want = pending_reports.pop_front();
        reports_checked++;
        if (want.data_updated)
            telemetry_reports++;
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: report mismatch, expected %s", $time, show(want));
                $display("%0t:                  actual   %s", $time, show(got));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_id  = 8'd1;
            wrap_lim = 12'd2048;
            idx_r    = 8'd0;
            hdr_r    = 1'b1;
            id_r     = 8'd0;
            len_r    = 8'd0;
            err_r    = 8'd0;
            sum_r    = 8'd0;
            foreach (pay_r[i])
                pay_r[i] = 8'd0;
            pos_now  = 16'd0;
            pos_prev = 16'd0;
            turns_r  = 16'd0;
            fresh_r  = 1'b1;
            pending_reports.delete();
            pending           = 0;
            mismatches        = 0;
            reports_checked   = 0;
            telemetry_reports = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                if (cfg_idx == CFG_EXPECTED_ID)
                    want_id = cfg_data[7:0];
                else
                    wrap_lim = cfg_data;
            end
            if (report_mon.valid === 1'b1 && report_mon.ready === 1'b1)
                check_report();
            if (byte_mon.valid === 1'b1 && byte_mon.ready === 1'b1)
                parse_byte(byte_mon.rx_byte, byte_mon.end_of_packet);
            pending = pending_reports.size();
        end
    end

endmodule

FILE: verif/servo_status_packet_parser_tb.sv
`timescale 1ns / 100ps

module servo_status_packet_parser_tb;
    import ssp_pkg::*;

    localparam int STEPS        = 4096;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_BYTES = 320;
    localparam int PHASES       = 8;
    localparam int LIMIT_NS     = 4000000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wen;
    logic        cfg_idx;
    logic [11:0] cfg_data;

    ssp_byte_if   byte_ch ();
    ssp_report_if report_ch ();

    int mismatches;
    int pending;
    int reports_checked;
    int telemetry_reports;

    logic [7:0] pkt [$];
    logic [7:0] cur_id;
    int         n_bytes    = 0;
    int         n_frames   = 0;
    int         n_settings = 0;
    bit         idle_on    = 1'b0;
    int         hold_token = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    servo_status_packet_parser #(
        .STEPS_PER_TURN (STEPS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .bytes    (byte_ch),
        .report   (report_ch),
        .cfg_wen  (cfg_wen),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    servo_status_packet_parser_checker #(
        .STEPS_PER_TURN (STEPS)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .byte_mon          (byte_ch),
        .report_mon        (report_ch),
        .cfg_wen           (cfg_wen),
        .cfg_idx           (cfg_idx),
        .cfg_data          (cfg_data),
        .mismatches        (mismatches),
        .pending           (pending),
        .reports_checked   (reports_checked),
        .telemetry_reports (telemetry_reports)
    );

    // report side: random stalls, plus long hold-offs on request
    initial
    begin
        int holds_done;
        holds_done = 0;
        report_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_token != holds_done)
            begin
                holds_done++;
                report_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                report_ch.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                report_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                report_ch.ready <= 1'b1;
            end
            else
                report_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #LIMIT_NS;
        $display("timeout at %0t, %0d reports still expected", $time, pending);
        $display("servo_status_packet_parser_tb: FAIL");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b, input logic eop);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            byte_ch.valid         <= 1'b0;
            byte_ch.rx_byte       <= 8'($urandom);
            byte_ch.end_of_packet <= 1'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.rx_byte       <= b;
        byte_ch.end_of_packet <= eop;
        do
            @(posedge clk);
        while (byte_ch.ready !== 1'b1);
        n_bytes++;
    endtask

    task automatic send_frame();
        foreach (pkt[i])
            push_byte(pkt[i], i == pkt.size() - 1);
        n_frames++;
    endtask

    // drain every outstanding request, then wait out the extra clocks that the argument asks for
    task automatic settle(input int extra);
        byte_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic retune(input logic [7:0] id, input logic [11:0] thr);
        settle(4);
        cfg_wen  <= 1'b1;
        cfg_idx  <= CFG_EXPECTED_ID;
        cfg_data <= {4'($urandom), id};
        @(posedge clk);
        cfg_idx  <= CFG_WRAP_THRESHOLD;
        cfg_data <= thr;
        @(posedge clk);
        cfg_wen  <= 1'b0;
        cur_id = id;
        n_settings++;
    endtask

    task automatic open_frame(input logic [7:0] id, input logic [7:0] len, input logic [7:0] err);
        pkt.delete();
        pkt.push_back(HEADER_BYTE);
        pkt.push_back(HEADER_BYTE);
        pkt.push_back(id);
        pkt.push_back(len);
        pkt.push_back(err);
    endtask

    task automatic seal();
        logic [7:0] s;
        s = 8'd0;
        for (int i = 2; i < pkt.size(); i++)
            s = s + pkt[i];
        pkt.push_back(~s);
    endtask

    task automatic telem(input logic [7:0] id, input logic [7:0] len, input logic [7:0] err,
                         input logic [15:0] pos, input logic [15:0] spd, input logic [15:0] ld,
                         input logic [7:0] volt, input logic [7:0] temp);
        open_frame(id, len, err);
        pkt.push_back(pos[7:0]);
        pkt.push_back(pos[15:8]);
        pkt.push_back(spd[7:0]);
        pkt.push_back(spd[15:8]);
        pkt.push_back(ld[7:0]);
        pkt.push_back(ld[15:8]);
        pkt.push_back(volt);
        pkt.push_back(temp);
        seal();
        send_frame();
    endtask

    task automatic random_frame();
        int         kind;
        int         n;
        int         cut;
        logic [7:0] len;

        kind = $urandom_range(0, 99);
        pkt.delete();
        if (kind < 90)
        begin
            n = (kind < 55) ? $urandom_range(13, 16) : $urandom_range(6, 12);
            if (kind < 55 && $urandom_range(0, 4) != 0)
                len = 8'($urandom_range(9, 255));
            else
                len = 8'($urandom);
            pkt.push_back(HEADER_BYTE);
            pkt.push_back(HEADER_BYTE);
            pkt.push_back(cur_id);
            pkt.push_back(len);
            while (pkt.size() < n - 1)
                pkt.push_back(8'($urandom));
            seal();
            if (kind >= 75)
            begin
                case ($urandom_range(0, 3))
                    0: pkt[$urandom_range(0, 1)] = 8'($urandom_range(0, 254));
                    1: pkt[2] = cur_id ^ 8'(1 << $urandom_range(0, 7));
                    2: pkt[n - 1] = pkt[n - 1] ^ 8'(1 << $urandom_range(0, 7));
                    default:
                    begin
                        cut = $urandom_range(1, 5);
                        while (pkt.size() > cut)
                            void'(pkt.pop_back());
                    end
                endcase
            end
        end
        else
        begin
            repeat ($urandom_range(1, 20))
                pkt.push_back(8'($urandom));
        end
        send_frame();
    endtask

    initial
    begin
        int         phase;
        int         goal;
        logic [7:0] id_pick;
        logic [11:0] thr_pick;

        rst_n                 <= 1'b0;
        cfg_wen               <= 1'b0;
        cfg_idx               <= CFG_EXPECTED_ID;
        cfg_data              <= 12'd0;
        byte_ch.valid         <= 1'b0;
        byte_ch.rx_byte       <= 8'd0;
        byte_ch.end_of_packet <= 1'b0;
        cur_id = 8'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed packets, reset settings: id 1, threshold 2048
        idle_on = 1'b1;
        pkt.delete();
        pkt.push_back(8'h00);
        send_frame();                               // lone end byte
        open_frame(8'd1, 8'd2, 8'd0);
        send_frame();                               // five bytes, too short
        open_frame(8'd1, 8'd2, 8'hFF);
        seal();
        send_frame();                               // smallest good packet
        open_frame(8'd1, 8'd2, 8'd0);
        seal();
        pkt[0] = 8'hFE;
        send_frame();
        open_frame(8'd1, 8'd2, 8'd0);
        seal();
        pkt[1] = 8'h00;
        send_frame();
        open_frame(8'd2, 8'd2, 8'd0);
        seal();
        send_frame();                               // wrong id
        open_frame(8'd1, 8'd2, 8'd0);
        seal();
        pkt[5] = pkt[5] ^ 8'h01;
        send_frame();                               // bad checksum
        // first sample, negative zero speed, max magnitudes
        telem(8'd1, 8'd10, 8'h00, 16'h0800, 16'h8000, 16'h7FFF, 8'hFF, 8'h00);
        telem(8'd1, 8'd9, 8'h01, 16'hF900, 16'hFFFF, 16'h8001, 8'h00, 8'hFF);   // backward jump
        telem(8'd1, 8'd255, 8'h80, 16'h0100, 16'h0001, 16'hFF00, 8'h7F, 8'h80); // exactly threshold
        telem(8'd1, 8'd12, 8'h7F, 16'h0901, 16'h00FF, 16'h0080, 8'h80, 8'h7F);  // one past threshold
        telem(8'd1, 8'd8, 8'h00, 16'h5555, 16'hAAAA, 16'h5555, 8'hAA, 8'h55);   // length too small
        open_frame(8'd1, 8'd9, 8'h00);
        repeat (6) pkt.push_back(8'($urandom));
        seal();
        send_frame();                               // 12 bytes, no telemetry
        open_frame(8'd1, 8'd9, 8'h00);
        repeat (7) pkt.push_back(8'($urandom));
        seal();
        send_frame();                               // 13 bytes, checksum doubles as temperature
        // over-long: index saturates, sum keeps running
        open_frame(8'd1, 8'd200, 8'h5A);
        repeat (294) pkt.push_back(8'($urandom));
        seal();
        send_frame();

        retune(8'd255, 12'd0);
        telem(8'd255, 8'd9, 8'h00, 16'h7FFF, 16'h1234, 16'h8765, 8'h10, 8'h20);
        telem(8'd254, 8'd9, 8'h00, 16'h7FFF, 16'h1234, 16'h8765, 8'h10, 8'h20);
        retune(8'd254, 12'hFFF);
        telem(8'd254, 8'd9, 8'h00, 16'h8000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        telem(8'd254, 8'd9, 8'h00, 16'h9000, 16'h0000, 16'h0000, 8'h00, 8'h00);
        retune(8'd0, 12'd1);
        telem(8'd0, 8'd9, 8'h00, 16'h9001, 16'h0000, 16'h0000, 8'h00, 8'h00);
        telem(8'd0, 8'd9, 8'h00, 16'h9003, 16'h0000, 16'h0000, 8'h00, 8'h00);

        // random phases, each under its own settings
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                retune(8'd0, 12'd0);
            else if (phase == 1)
                retune(8'd253, 12'hFFF);
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    id_pick = 8'($urandom_range(253, 255));
                else
                    id_pick = 8'($urandom);
                if ($urandom_range(0, 3) == 0)
                    thr_pick = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                else
                    thr_pick = 12'($urandom);
                retune(id_pick, thr_pick);
            end
            idle_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);

            if (phase == 3)
            begin
                // long report hold-off while short packets keep coming
                hold_token++;
                repeat (24)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        pkt.delete();
                        pkt.push_back(8'($urandom));
                    end
                    else
                    begin
                        open_frame(cur_id, 8'd2, 8'($urandom));
                        seal();
                    end
                    send_frame();
                end
            end

            goal = n_bytes + RANDOM_BYTES / PHASES;
            while (n_bytes < goal)
                random_frame();
        end

        settle(12);
        $display("ran %0d bytes in %0d packets under %0d register settings", n_bytes, n_frames,
                 n_settings + 1);
        $display("checked %0d reports, %0d with telemetry", reports_checked, telemetry_reports);
        if (pending != 0)
            $display("%0d expected reports never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("servo_status_packet_parser_tb: PASS");
        else
            $display("servo_status_packet_parser_tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hdl/ssp_pkg.sv
hdl/ssp_if.sv
hdl/ssp_collect.sv
hdl/ssp_telemetry.sv
hdl/servo_status_packet_parser.sv
verif/servo_status_packet_parser_checker.sv
verif/servo_status_packet_parser_tb.sv
